// File: hdl/gcps_pkg.sv
// Package for the greedy coin payout selector.
// Holds item types, op codes, sequencer states and sizing constants.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package gcps_pkg;

  // Number of tubes in the table and the width of a tube index.
  localparam int unsigned TUBE_COUNT = 16;
  localparam int unsigned TubeIdxW   = 4;
  localparam int unsigned ValueW     = 16;
  localparam int unsigned StockW     = 8;
  localparam int unsigned CountW     = 4;
  // Width of the shared compare and subtract unit: a value shifted by up to four.
  localparam int unsigned AluW       = ValueW + CountW;
  // Shift that tests for a quotient of sixteen or more.
  localparam logic [2:0]  SatShift   = 3'd4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [TubeIdxW-1:0] tube_index;
    logic                tube_active;
    logic                tube_is_token;
    logic [StockW-1:0]   tube_stock;
    logic [ValueW-1:0]   coin_value;
    logic [ValueW-1:0]   payout_amount;
  } in_item_t;

  typedef struct packed {
    logic [TubeIdxW-1:0] tube_sel;
    logic [CountW-1:0]   coin_count;
    logic                finished;
    logic                success;
    logic [ValueW-1:0]   remaining;
  } out_item_t;

  // One tube entry as stored in the table.
  typedef struct packed {
    logic              active;
    logic              token;
    logic [StockW-1:0] stock;
    logic [ValueW-1:0] value;
  } tube_entry_t;

  // Write request into the tube table.
  typedef struct packed {
    logic                en;
    logic [TubeIdxW-1:0] idx;
    tube_entry_t         entry;
  } tube_wr_t;

endpackage

`default_nettype wire

// File: hdl/gcps_tube_table.sv
// Tube table of the payout selector: one entry per coin tube.
// Uses tube_entry_t and tube_wr_t from gcps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcps_tube_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gcps_pkg::tube_wr_t        wr_i,
  input  logic [gcps_pkg::TubeIdxW-1:0] rd_idx_i,
  output gcps_pkg::tube_entry_t     rd_entry_o
);
  import gcps_pkg::*;

  logic [TUBE_COUNT-1:0] active_q;
  tube_entry_t           entry_q [TUBE_COUNT];

  // Active flags reset to zero, so an unwritten tube is never usable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (wr_i.en) begin
      active_q[wr_i.idx] <= wr_i.entry.active;
    end
  end

  // Entry payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      entry_q[wr_i.idx] <= wr_i.entry;
    end
  end

  // Read port for the scan.
  always_comb begin
    rd_entry_o        = entry_q[rd_idx_i];
    rd_entry_o.active = active_q[rd_idx_i];
  end

endmodule

`default_nettype wire

// File: hdl/gcps_cmp_sub.sv
// Shared compare and subtract unit of the payout selector.
// Serves the best-value compare of the scan and each division step.
`timescale 1ns / 1ps
`default_nettype none

module gcps_cmp_sub (
  input  logic [gcps_pkg::AluW-1:0] a_i,
  input  logic [gcps_pkg::AluW-1:0] b_i,
  output logic                      ge_o,
  output logic [gcps_pkg::AluW-1:0] diff_o
);
  import gcps_pkg::*;

  logic [AluW:0] wide;

  // One subtraction gives both the difference and the borrow.
  always_comb begin
    wide   = {1'b0, a_i} - {1'b0, b_i};
    ge_o   = ~wide[AluW];
    diff_o = wide[AluW-1:0];
  end

endmodule

`default_nettype wire

// File: hdl/greedy_coin_payout_selector.sv
// Top level of the greedy coin payout selector: sequencer, remainder and output register.
// Instantiates gcps_tube_table and gcps_cmp_sub; types from gcps_pkg.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (out_item_t)
//
// Write, start and unused op items give no result.
// A step item scans the tubes one per cycle, then runs the division on the
// shared compare and subtract unit if a tube was found, and then loads the
// output register once it is free.
// Reset clears the tube active flags, the remainder, the sequencer and the output valid.
// A stalled result holds in the output register; the block takes the next item meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module greedy_coin_payout_selector (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gcps_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gcps_pkg::out_item_t out_item_o
);
  import gcps_pkg::*;

  localparam logic [TubeIdxW-1:0] LastIdx = TubeIdxW'(TUBE_COUNT - 1);

  state_e              state_q, state_d;
  logic [ValueW-1:0]   rem_q, rem_d;
  logic [ValueW-1:0]   part_q, part_d;
  logic [ValueW-1:0]   best_val_q, best_val_d;
  logic [TubeIdxW-1:0] best_idx_q, best_idx_d;
  logic                found_q, found_d;
  logic [TubeIdxW-1:0] scan_idx_q, scan_idx_d;
  logic [2:0]          div_k_q, div_k_d;
  logic                sat_q, sat_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  tube_wr_t            tube_wr;
  tube_entry_t         entry;
  logic [AluW-1:0]     alu_a, alu_b, alu_diff;
  logic                alu_ge;
  logic                accept;
  logic                usable;
  logic                better;

  gcps_tube_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tube_wr),
    .rd_idx_i   (scan_idx_q),
    .rd_entry_o (entry)
  );

  gcps_cmp_sub u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .ge_o   (alu_ge),
    .diff_o (alu_diff)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Operands of the shared unit: best-value compare while scanning, trial subtract while dividing.
  always_comb begin
    if (state_q == ST_DIV) begin
      alu_a = AluW'(part_q);
      alu_b = AluW'(best_val_q) << div_k_q;
    end else begin
      alu_a = AluW'(best_val_q);
      alu_b = AluW'(entry.value);
    end
  end

  // Usable test for the entry under the scan; better when the best so far is lower.
  always_comb begin
    usable = entry.active && !entry.token && (entry.stock != '0) &&
             (entry.value != '0) && (entry.value <= rem_q);
    better = usable && (!found_q || !alu_ge);
  end

  // Table write for accepted write items.
  always_comb begin
    tube_wr.en          = accept && (op_e'(in_item_i.op) == OP_WRITE) &&
                          ({1'b0, in_item_i.tube_index} < (TubeIdxW + 1)'(TUBE_COUNT));
    tube_wr.idx         = in_item_i.tube_index;
    tube_wr.entry.active = in_item_i.tube_active;
    tube_wr.entry.token = in_item_i.tube_is_token;
    tube_wr.entry.stock = in_item_i.tube_stock;
    tube_wr.entry.value = in_item_i.coin_value;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    part_d      = part_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    found_d     = found_q;
    scan_idx_d  = scan_idx_q;
    div_k_d     = div_k_q;
    sat_d       = sat_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(in_item_i.op))
            OP_START: rem_d = in_item_i.payout_amount;
            OP_STEP: begin
              state_d    = ST_SCAN;
              scan_idx_d = '0;
              found_d    = 1'b0;
            end
            OP_WRITE, OP_NONE: ;
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (better) begin
          found_d    = 1'b1;
          best_val_d = entry.value;
          best_idx_d = scan_idx_q;
        end
        if (scan_idx_q == LastIdx) begin
          part_d  = rem_q;
          div_k_d = SatShift;
          sat_d   = 1'b0;
          count_d = '0;
          state_d = (found_q || better) ? ST_DIV : ST_OUT;
        end else begin
          scan_idx_d = scan_idx_q + TubeIdxW'(1);
        end
      end

      ST_DIV: begin
        if (div_k_q == SatShift) begin
          // Quotient of sixteen or more: every following step subtracts.
          sat_d = alu_ge;
        end else if (sat_q || alu_ge) begin
          part_d                  = alu_diff[ValueW-1:0];
          count_d[div_k_q[1:0]]   = 1'b1;
        end
        if (div_k_q == '0) begin
          state_d = ST_OUT;
        end else begin
          div_k_d = div_k_q - 3'd1;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (found_q) begin
            rem_d                 = part_q;
            out_item_d.tube_sel   = best_idx_q;
            out_item_d.coin_count = count_q;
            out_item_d.finished   = 1'b0;
            out_item_d.success    = 1'b0;
            out_item_d.remaining  = part_q;
          end else begin
            out_item_d.tube_sel   = '0;
            out_item_d.coin_count = '0;
            out_item_d.finished   = 1'b1;
            out_item_d.success    = (rem_q == '0);
            out_item_d.remaining  = rem_q;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      found_q     <= 1'b0;
      scan_idx_q  <= '0;
      div_k_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      found_q     <= found_d;
      scan_idx_q  <= scan_idx_d;
      div_k_q     <= div_k_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    part_q     <= part_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    count_q    <= count_d;
    out_item_q <= out_item_d;
  end

endmodule

`default_nettype wire

// File: hdl/gcps_checker.sv
// Port-level checks for the greedy coin payout selector, bound to the top level.
// Uses op_e from gcps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input gcps_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gcps_pkg::out_item_t out_item_o
);
  import gcps_pkg::*;

  // A result that is stalled stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result item dropped");

  // An accepted step item keeps the input side busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_e'(in_item_i.op) == OP_STEP) |=> in_stall_o)
    else $error("step item did not occupy the sequencer");

  // A finished result names no tube and dispenses nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.finished |->
      (out_item_o.coin_count == '0) && (out_item_o.tube_sel == '0))
    else $error("finished item carries a dispense");

  // A dispense result dispenses at least one coin and never reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.finished |->
      (out_item_o.coin_count != '0) && !out_item_o.success)
    else $error("dispense item malformed");

  // Success only comes with finished and a zero remainder.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.success |->
      out_item_o.finished && (out_item_o.remaining == '0))
    else $error("success without zero remainder");

endmodule

bind greedy_coin_payout_selector gcps_checker u_gcps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
